### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check on aclk, disabled in reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/hpack_pkg.sv
`timescale 1ns / 1ps
package hpack_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } hpack_in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } hpack_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture input item and look up code
        logic emit;   // output register takes the next byte
        logic finish; // commit residue after the item
    } hpack_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_byte; // at least one byte pending
        logic last_one;  // pending byte is the final one of the string
    } hpack_sts_t;

    localparam int unsigned EOS_LEN = 30;
    localparam logic [29:0] EOS_CODE = 30'h3fffffff;

    function automatic logic [29:0] hp_code(input logic [7:0] s);
        logic [29:0] c;
        unique case (s)
8'd0: c=30'h1ff8; 8'd1: c=30'h7fffd8; 8'd2: c=30'hfffffe2; 8'd3: c=30'hfffffe3;
8'd4: c=30'hfffffe4; 8'd5: c=30'hfffffe5; 8'd6: c=30'hfffffe6; 8'd7: c=30'hfffffe7;
8'd8: c=30'hfffffe8; 8'd9: c=30'hffffea; 8'd10: c=30'h3ffffffc; 8'd11: c=30'hfffffe9;
8'd12: c=30'hfffffea; 8'd13: c=30'h3ffffffd; 8'd14: c=30'hfffffeb; 8'd15: c=30'hfffffec;
8'd16: c=30'hfffffed; 8'd17: c=30'hfffffee; 8'd18: c=30'hfffffef; 8'd19: c=30'hffffff0;
8'd20: c=30'hffffff1; 8'd21: c=30'hffffff2; 8'd22: c=30'h3ffffffe; 8'd23: c=30'hffffff3;
8'd24: c=30'hffffff4; 8'd25: c=30'hffffff5; 8'd26: c=30'hffffff6; 8'd27: c=30'hffffff7;
8'd28: c=30'hffffff8; 8'd29: c=30'hffffff9; 8'd30: c=30'hffffffa; 8'd31: c=30'hffffffb;
8'd32: c=30'h14; 8'd33: c=30'h3f8; 8'd34: c=30'h3f9; 8'd35: c=30'hffa;
8'd36: c=30'h1ff9; 8'd37: c=30'h15; 8'd38: c=30'hf8; 8'd39: c=30'h7fa;
8'd40: c=30'h3fa; 8'd41: c=30'h3fb; 8'd42: c=30'hf9; 8'd43: c=30'h7fb;
8'd44: c=30'hfa; 8'd45: c=30'h16; 8'd46: c=30'h17; 8'd47: c=30'h18;
8'd48: c=30'h0; 8'd49: c=30'h1; 8'd50: c=30'h2; 8'd51: c=30'h19;
8'd52: c=30'h1a; 8'd53: c=30'h1b; 8'd54: c=30'h1c; 8'd55: c=30'h1d;
8'd56: c=30'h1e; 8'd57: c=30'h1f; 8'd58: c=30'h5c; 8'd59: c=30'hfb;
8'd60: c=30'h7ffc; 8'd61: c=30'h20; 8'd62: c=30'hffb; 8'd63: c=30'h3fc;
8'd64: c=30'h1ffa; 8'd65: c=30'h21; 8'd66: c=30'h5d; 8'd67: c=30'h5e;
8'd68: c=30'h5f; 8'd69: c=30'h60; 8'd70: c=30'h61; 8'd71: c=30'h62;
8'd72: c=30'h63; 8'd73: c=30'h64; 8'd74: c=30'h65; 8'd75: c=30'h66;
8'd76: c=30'h67; 8'd77: c=30'h68; 8'd78: c=30'h69; 8'd79: c=30'h6a;
8'd80: c=30'h6b; 8'd81: c=30'h6c; 8'd82: c=30'h6d; 8'd83: c=30'h6e;
8'd84: c=30'h6f; 8'd85: c=30'h70; 8'd86: c=30'h71; 8'd87: c=30'h72;
8'd88: c=30'hfc; 8'd89: c=30'h73; 8'd90: c=30'hfd; 8'd91: c=30'h1ffb;
8'd92: c=30'h7fff0; 8'd93: c=30'h1ffc; 8'd94: c=30'h3ffc; 8'd95: c=30'h22;
8'd96: c=30'h7ffd; 8'd97: c=30'h3; 8'd98: c=30'h23; 8'd99: c=30'h4;
8'd100: c=30'h24; 8'd101: c=30'h5; 8'd102: c=30'h25; 8'd103: c=30'h26;
8'd104: c=30'h27; 8'd105: c=30'h6; 8'd106: c=30'h74; 8'd107: c=30'h75;
8'd108: c=30'h28; 8'd109: c=30'h29; 8'd110: c=30'h2a; 8'd111: c=30'h7;
8'd112: c=30'h2b; 8'd113: c=30'h76; 8'd114: c=30'h2c; 8'd115: c=30'h8;
8'd116: c=30'h9; 8'd117: c=30'h2d; 8'd118: c=30'h77; 8'd119: c=30'h78;
8'd120: c=30'h79; 8'd121: c=30'h7a; 8'd122: c=30'h7b; 8'd123: c=30'h7ffe;
8'd124: c=30'h7fc; 8'd125: c=30'h3ffd; 8'd126: c=30'h1ffd; 8'd127: c=30'hffffffc;
8'd128: c=30'hfffe6; 8'd129: c=30'h3fffd2; 8'd130: c=30'hfffe7; 8'd131: c=30'hfffe8;
8'd132: c=30'h3fffd3; 8'd133: c=30'h3fffd4; 8'd134: c=30'h3fffd5; 8'd135: c=30'h7fffd9;
8'd136: c=30'h3fffd6; 8'd137: c=30'h7fffda; 8'd138: c=30'h7fffdb; 8'd139: c=30'h7fffdc;
8'd140: c=30'h7fffdd; 8'd141: c=30'h7fffde; 8'd142: c=30'hffffeb; 8'd143: c=30'h7fffdf;
8'd144: c=30'hffffec; 8'd145: c=30'hffffed; 8'd146: c=30'h3fffd7; 8'd147: c=30'h7fffe0;
8'd148: c=30'hffffee; 8'd149: c=30'h7fffe1; 8'd150: c=30'h7fffe2; 8'd151: c=30'h7fffe3;
8'd152: c=30'h7fffe4; 8'd153: c=30'h1fffdc; 8'd154: c=30'h3fffd8; 8'd155: c=30'h7fffe5;
8'd156: c=30'h3fffd9; 8'd157: c=30'h7fffe6; 8'd158: c=30'h7fffe7; 8'd159: c=30'hffffef;
8'd160: c=30'h3fffda; 8'd161: c=30'h1fffdd; 8'd162: c=30'hfffe9; 8'd163: c=30'h3fffdb;
8'd164: c=30'h3fffdc; 8'd165: c=30'h7fffe8; 8'd166: c=30'h7fffe9; 8'd167: c=30'h1fffde;
8'd168: c=30'h7fffea; 8'd169: c=30'h3fffdd; 8'd170: c=30'h3fffde; 8'd171: c=30'hfffff0;
8'd172: c=30'h1fffdf; 8'd173: c=30'h3fffdf; 8'd174: c=30'h7fffeb; 8'd175: c=30'h7fffec;
8'd176: c=30'h1fffe0; 8'd177: c=30'h1fffe1; 8'd178: c=30'h3fffe0; 8'd179: c=30'h1fffe2;
8'd180: c=30'h7fffed; 8'd181: c=30'h3fffe1; 8'd182: c=30'h7fffee; 8'd183: c=30'h7fffef;
8'd184: c=30'hfffea; 8'd185: c=30'h3fffe2; 8'd186: c=30'h3fffe3; 8'd187: c=30'h3fffe4;
8'd188: c=30'h7ffff0; 8'd189: c=30'h3fffe5; 8'd190: c=30'h3fffe6; 8'd191: c=30'h7ffff1;
8'd192: c=30'h3ffffe0; 8'd193: c=30'h3ffffe1; 8'd194: c=30'hfffeb; 8'd195: c=30'h7fff1;
8'd196: c=30'h3fffe7; 8'd197: c=30'h7ffff2; 8'd198: c=30'h3fffe8; 8'd199: c=30'h1ffffec;
8'd200: c=30'h3ffffe2; 8'd201: c=30'h3ffffe3; 8'd202: c=30'h3ffffe4; 8'd203: c=30'h7ffffde;
8'd204: c=30'h7ffffdf; 8'd205: c=30'h3ffffe5; 8'd206: c=30'hfffff1; 8'd207: c=30'h1ffffed;
8'd208: c=30'h7fff2; 8'd209: c=30'h1fffe3; 8'd210: c=30'h3ffffe6; 8'd211: c=30'h7ffffe0;
8'd212: c=30'h7ffffe1; 8'd213: c=30'h3ffffe7; 8'd214: c=30'h7ffffe2; 8'd215: c=30'hfffff2;
8'd216: c=30'h1fffe4; 8'd217: c=30'h1fffe5; 8'd218: c=30'h3ffffe8; 8'd219: c=30'h3ffffe9;
8'd220: c=30'hffffffd; 8'd221: c=30'h7ffffe3; 8'd222: c=30'h7ffffe4; 8'd223: c=30'h7ffffe5;
8'd224: c=30'hfffec; 8'd225: c=30'hfffff3; 8'd226: c=30'hfffed; 8'd227: c=30'h1fffe6;
8'd228: c=30'h3fffe9; 8'd229: c=30'h1fffe7; 8'd230: c=30'h1fffe8; 8'd231: c=30'h7ffff3;
8'd232: c=30'h3fffea; 8'd233: c=30'h3fffeb; 8'd234: c=30'h1ffffee; 8'd235: c=30'h1ffffef;
8'd236: c=30'hfffff4; 8'd237: c=30'hfffff5; 8'd238: c=30'h3ffffea; 8'd239: c=30'h7ffff4;
8'd240: c=30'h3ffffeb; 8'd241: c=30'h7ffffe6; 8'd242: c=30'h3ffffec; 8'd243: c=30'h3ffffed;
8'd244: c=30'h7ffffe7; 8'd245: c=30'h7ffffe8; 8'd246: c=30'h7ffffe9; 8'd247: c=30'h7ffffea;
8'd248: c=30'h7ffffeb; 8'd249: c=30'hffffffe; 8'd250: c=30'h7ffffec; 8'd251: c=30'h7ffffed;
8'd252: c=30'h7ffffee; 8'd253: c=30'h7ffffef; 8'd254: c=30'h7fffff0; 8'd255: c=30'h3ffffee;
            default: c = '0;
        endcase
        return c;
    endfunction

    // code length per symbol, symbol 0 first
    localparam logic [0:255][4:0] HP_LEN = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26
    };

endpackage

### sv/hpack_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpack_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  hpack_pkg::hpack_sts_t sts,
    output hpack_pkg::hpack_cmd_t cmd,
    output logic                 out_last
);
    import hpack_pkg::*;

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   olast_reg, olast_next;
    logic   slot_free;

    // output register free now or freed this cycle
    assign slot_free = !ovalid_reg || m_ready;
    assign s_ready   = (state_reg == IDLE);
    assign m_valid   = ovalid_reg;
    assign out_last  = olast_reg;

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !m_ready;
        olast_next  = olast_reg;
        cmd         = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = EMIT;
                end
            end
            EMIT: begin
                if (!sts.have_byte) begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end else if (slot_free) begin
                    cmd.emit    = 1'b1;
                    ovalid_next = 1'b1;
                    olast_next  = sts.last_one;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            olast_reg  <= olast_next;
        end
    end

    `ASSERT_IMPL(a_emit_in_emit, cmd.emit, state_reg == EMIT)
    `ASSERT_NEXT(a_hold_stall, m_valid && !m_ready, m_valid && $stable(out_last))
    `ASSERT_IMPL(a_no_load_twice, cmd.load, !cmd.emit && !cmd.finish)
endmodule

### sv/hpack_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpack_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hpack_pkg::hpack_in_t  s_item,
    input  hpack_pkg::hpack_cmd_t cmd,
    output hpack_pkg::hpack_sts_t sts,
    output logic [7:0]            byte_out
);
    import hpack_pkg::*;

    logic [36:0] acc_reg, acc_next;      // residue and code, right aligned
    logic [5:0]  cnt_reg, cnt_next;      // pending bits
    logic        last_reg, last_next;
    logic [6:0]  res_reg, res_next;
    logic [2:0]  rcnt_reg, rcnt_next;
    logic [7:0]  byte_reg, byte_next;
    logic [29:0] code;
    logic [4:0]  len;
    logic [5:0]  sh;
    logic [7:0]  top;
    logic [7:0]  padded;
    logic [2:0]  padn;

    assign code = hp_code(s_item.symbol);
    assign len  = HP_LEN[s_item.symbol];

    // next byte taken from the top of the pending bits
    assign sh   = cnt_reg - 6'd8;
    assign top  = 8'(acc_reg >> sh);
    assign padn = 3'(4'd8 - {1'b0, cnt_reg[2:0]});
    // leftover bits on top, leading eos one-bits below
    assign padded = 8'({acc_reg[6:0], EOS_CODE[EOS_LEN-1 -: 8]} >> cnt_reg[2:0]);

    always_comb begin
        sts.have_byte = (cnt_reg >= 6'd8) || (last_reg && cnt_reg != 6'd0);
        sts.last_one  = last_reg &&
                        ((cnt_reg < 6'd8) || (cnt_reg == 6'd8));
    end

    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        res_next  = res_reg;
        rcnt_next = rcnt_reg;
        byte_next = byte_reg;
        if (cmd.load) begin
            acc_next  = (37'(res_reg) << len) | 37'(code);
            cnt_next  = 6'(rcnt_reg) + 6'(len);
            last_next = s_item.last_symbol;
        end else if (cmd.emit) begin
            if (cnt_reg >= 6'd8) begin
                byte_next = top;
                cnt_next  = sh;
            end else begin
                byte_next = padded;
                cnt_next  = '0;
            end
        end else if (cmd.finish) begin
            res_next  = last_reg ? 7'd0 : 7'(acc_reg);
            rcnt_next = last_reg ? 3'd0 : cnt_reg[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg  <= '0;
            rcnt_reg <= '0;
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end else begin
            res_reg  <= res_next;
            rcnt_reg <= rcnt_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

    `ASSERT_IMPL(a_pad_small, cmd.emit && cnt_reg < 6'd8, last_reg && padn != 3'd0)
    `ASSERT_NEXT(a_fin_clear, cmd.finish && last_reg, rcnt_reg == 3'd0)
endmodule

### sv/hpack_huffman_encoder.sv
`timescale 1ns / 1ps
// hpack static huffman string encoder
// s_ channel: one string byte per item (symbol) with last_symbol on the final byte
// m_ channel: coded bytes, msb first; last_byte marks the final byte of a string
// each item looks up a 5..30 bit code from a constant table, appends it to
// up to 7 residue bits, and sends every complete byte one per cycle while m_ready stays high
// a string that ends off a byte boundary has its final byte filled out with one-bits
// each item produces 0 to 5 coded bytes
// the byte sequencer moves at most one byte a cycle into the output register
// the item is loaded first; its first byte then enters the output register once that register is free
// reset (aresetn low, synchronous) clears the residue and empties the output
// a stalled receiver holds m_valid and the byte; the sequencer waits and
// s_ready stays low until all bytes of the current item are in the register
module hpack_huffman_encoder (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hpack_pkg::hpack_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hpack_pkg::hpack_out_t  m_data
);
    import hpack_pkg::*;

    hpack_cmd_t cmd;     // controller commands
    hpack_sts_t sts;     // datapath status
    logic [7:0] byte_q;  // output byte register
    logic       last_q;  // final-byte flag

    hpack_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd),
        .out_last (last_q)
    );

    hpack_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .byte_out (byte_q)
    );

    assign m_data.code_byte = byte_q;
    assign m_data.last_byte = last_q;

    `ASSERT_IMPL(a_busy_no_take, m_valid && !s_ready, !(s_valid && s_ready))
endmodule
